// ===== sv/acpi_power_state_sequencer_top_macros.svh =====
// Assertion macros for the power sequencer top level
`ifndef ACPI_POWER_STATE_SEQUENCER_TOP_MACROS_SVH
`define ACPI_POWER_STATE_SEQUENCER_TOP_MACROS_SVH
// a implies b at the same edge
`define APS_ASSERT_IMPL(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);
// a implies b at the next edge
`define APS_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);
`endif

// ===== sv/aps_pkg.sv =====
// Types, codes and constants of the power sequencer
`timescale 1ns / 1ps
package aps_pkg;
    localparam int TimerW = 16;
    localparam logic [TimerW-1:0] TimerMax = {TimerW{1'b1}};
    localparam int QDepth = 4;

    typedef enum logic [1:0] {
        OP_EVAL  = 2'd0,
        OP_TICK  = 2'd1,
        OP_START = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [3:0] {
        ST_G3 = 4'd0, ST_S5 = 4'd1, ST_S4 = 4'd2, ST_S3 = 4'd3,
        ST_S0IX = 4'd4, ST_S0 = 4'd5, ST_G3S5 = 4'd6, ST_S5S4 = 4'd7,
        ST_S4S3 = 4'd8, ST_S3S0 = 4'd9, ST_S5G3 = 4'd10, ST_S4S5 = 4'd11,
        ST_S3S4 = 4'd12, ST_S0S3 = 4'd13, ST_S0IXS0 = 4'd14, ST_S0S0IX = 4'd15
    } t_state;

    localparam logic [3:0] EV_NONE = 4'd0, EV_SHUTDOWN = 4'd1, EV_COMPLETE = 4'd2,
        EV_FORCE_G3 = 4'd3, EV_FORCE_FAIL = 4'd4, EV_HARDOFF = 4'd5,
        EV_STARTUP = 4'd6, EV_RESUME = 4'd7, EV_SUSPEND = 4'd8,
        EV_S0IX_SUSPEND = 4'd9, EV_S0IX_RESUME = 4'd10, EV_SLEEP_SUSPEND = 4'd11,
        EV_SLEEP_RESUME = 4'd12;

    localparam logic [1:0] HS_SUSPEND = 2'd1, HS_RESUME = 2'd2;

    localparam logic [2:0] REG_S5_TIMEOUT = 3'd0, REG_START_DELAY = 3'd1,
        REG_G3S5_MASK = 3'd2, REG_G3S5_VALUE = 3'd3, REG_DEBUG_HOLD = 3'd4,
        REG_S0IX_ENABLE = 3'd5;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] signals;
        logic [2:0] wire_valid;
        logic       rails_enabled;
        logic       startup_ok;
        logic [1:0] host_sleep;
    } t_in_item;

    typedef struct packed {
        logic [3:0] seq_state;
        logic [3:0] event_res;
        logic       rsmrst_assert;
        logic       deep_sleep_ok;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [16:0] s5_timeout;
        logic [15:0] start_delay;
        logic [7:0]  g3s5_mask;
        logic [7:0]  g3s5_value;
        logic        debug_hold;
        logic        s0ix_enable;
    } t_cfg;

    // one classified item: up to four events plus the levels after the step
    typedef struct packed {
        logic [3:0] seq_state;
        logic       rsmrst_assert;
        logic       deep_sleep_ok;
        logic [2:0] nev;
        logic [3:0][3:0] ev;
    } t_step;
endpackage

// ===== sv/aps_cfg.sv =====
// APB register file of the power sequencer
`timescale 1ns / 1ps
module aps_cfg (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    output aps_pkg::t_cfg o_cfg,
    output logic         o_delay_rearm
);
    aps_pkg::t_cfg r_cfg;
    logic          wr;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr = psel & penable & pwrite;
    assign idx = paddr[4:2];
    assign o_cfg = r_cfg;
    assign o_delay_rearm = wr && idx == aps_pkg::REG_START_DELAY;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.s5_timeout  <= 17'd10;
            r_cfg.start_delay <= 16'd0;
            r_cfg.g3s5_mask   <= 8'd16;
            r_cfg.g3s5_value  <= 8'd16;
            r_cfg.debug_hold  <= 1'b0;
            r_cfg.s0ix_enable <= 1'b0;
        end else if (wr) begin
            unique case (idx)
                aps_pkg::REG_S5_TIMEOUT:  r_cfg.s5_timeout  <= pwdata[16:0];
                aps_pkg::REG_START_DELAY: r_cfg.start_delay <= pwdata[15:0];
                aps_pkg::REG_G3S5_MASK:   r_cfg.g3s5_mask   <= pwdata[7:0];
                aps_pkg::REG_G3S5_VALUE:  r_cfg.g3s5_value  <= pwdata[7:0];
                aps_pkg::REG_DEBUG_HOLD:  r_cfg.debug_hold  <= pwdata[0];
                aps_pkg::REG_S0IX_ENABLE: r_cfg.s0ix_enable <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (idx)
            aps_pkg::REG_S5_TIMEOUT:  prdata = {15'd0, r_cfg.s5_timeout};
            aps_pkg::REG_START_DELAY: prdata = {16'd0, r_cfg.start_delay};
            aps_pkg::REG_G3S5_MASK:   prdata = {24'd0, r_cfg.g3s5_mask};
            aps_pkg::REG_G3S5_VALUE:  prdata = {24'd0, r_cfg.g3s5_value};
            aps_pkg::REG_DEBUG_HOLD:  prdata = {31'd0, r_cfg.debug_hold};
            aps_pkg::REG_S0IX_ENABLE: prdata = {31'd0, r_cfg.s0ix_enable};
            default: prdata = 32'd0;
        endcase
    end
endmodule

// ===== sv/aps_front.sv =====
// Front end: holds sequencer state, takes items and classifies each into events
`timescale 1ns / 1ps
module aps_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  aps_pkg::t_cfg   i_cfg,
    input  logic            i_delay_rearm,
    input  logic            i_push,
    input  aps_pkg::t_in_item i_item,
    output logic            o_step_valid,
    output aps_pkg::t_step  o_step
);
    aps_pkg::t_state r_state, n_state;
    logic        r_pending, n_pending;
    logic        r_run, n_run;
    logic [aps_pkg::TimerW-1:0] r_s5cnt, n_s5cnt, r_dcnt, n_dcnt;
    logic        r_armed, n_armed;
    logic        r_rsm, n_rsm;
    logic        r_ds, n_ds;
    logic [2:0]  nev;
    logic [3:0][3:0] ev;
    logic [7:0]  sig;
    logic [2:0]  wv;
    logic        rsm, prim;
    logic [aps_pkg::TimerW-1:0] s5_sat, dl_sat;

    assign sig  = i_item.signals;
    assign wv   = i_item.wire_valid;
    assign rsm  = sig[4];
    assign prim = sig[6];
    assign s5_sat = (i_cfg.s5_timeout[15:0] > 16'(aps_pkg::TimerMax)) ?
                    aps_pkg::TimerMax : aps_pkg::TimerW'(i_cfg.s5_timeout[15:0]);
    assign dl_sat = (i_cfg.start_delay > 16'(aps_pkg::TimerMax)) ?
                    aps_pkg::TimerMax : aps_pkg::TimerW'(i_cfg.start_delay);

    always_comb begin
        n_state = r_state; n_pending = r_pending; n_run = r_run;
        n_s5cnt = r_s5cnt; n_dcnt = r_dcnt; n_armed = r_armed;
        n_rsm = r_rsm; n_ds = r_ds;
        nev = 3'd0;
        ev = '0;
        if (i_push) begin
            unique case (aps_pkg::t_op'(i_item.op))
                aps_pkg::OP_EVAL: begin
                    unique case (r_state) inside
                        aps_pkg::ST_G3: begin
                            if (r_pending) begin
                                if (r_armed) begin
                                    n_dcnt = dl_sat;
                                    n_armed = 1'b0;
                                end
                                if (n_dcnt == '0) begin
                                    n_pending = 1'b0;
                                    if (i_item.startup_ok) n_state = aps_pkg::ST_G3S5;
                                end
                            end
                        end
                        aps_pkg::ST_G3S5:
                            n_state = ((sig & i_cfg.g3s5_mask) == i_cfg.g3s5_value) ?
                                      aps_pkg::ST_S5 : aps_pkg::ST_S5G3;
                        aps_pkg::ST_S5: begin
                            if (i_item.rails_enabled && rsm) n_rsm = 1'b0;
                            if (i_item.rails_enabled && rsm && wv[2] && !sig[3]) begin
                                n_run = 1'b0; n_pending = 1'b0;
                                n_state = aps_pkg::ST_S5S4;
                            end else if (i_cfg.s5_timeout == '0) begin
                                n_run = 1'b0;
                                n_state = aps_pkg::ST_S5G3;
                            end else if (!i_cfg.s5_timeout[16]) begin
                                if (!r_run) begin
                                    n_run = 1'b1;
                                    n_s5cnt = s5_sat;
                                end else if (r_s5cnt == '0) begin
                                    n_run = 1'b0;
                                    n_state = aps_pkg::ST_S5G3;
                                end
                            end
                        end
                        aps_pkg::ST_S5G3: begin
                            if (!i_cfg.debug_hold) begin
                                ev[0] = aps_pkg::EV_FORCE_G3;
                                ev[1] = aps_pkg::EV_HARDOFF; nev = 3'd2;
                            end else begin
                                ev[0] = aps_pkg::EV_HARDOFF; nev = 3'd1;
                            end
                            n_state = aps_pkg::ST_G3;
                        end
                        aps_pkg::ST_S5S4:
                            n_state = rsm ? aps_pkg::ST_S4 : aps_pkg::ST_S5;
                        aps_pkg::ST_S4: begin
                            if ((wv[2] && sig[3]) || !rsm) n_state = aps_pkg::ST_S4S5;
                            else if (wv[1] && !sig[2]) n_state = aps_pkg::ST_S4S3;
                        end
                        aps_pkg::ST_S4S3, aps_pkg::ST_S3, aps_pkg::ST_S3S0,
                        aps_pkg::ST_S0: begin
                            if (r_state == aps_pkg::ST_S3 && !rsm) begin
                                n_state = aps_pkg::ST_S3S4;
                            end else if (!prim) begin
                                ev[0] = aps_pkg::EV_SHUTDOWN;
                                if (!i_cfg.debug_hold) begin
                                    ev[1] = aps_pkg::EV_FORCE_FAIL;
                                    ev[2] = aps_pkg::EV_COMPLETE; nev = 3'd3;
                                end else begin
                                    ev[1] = aps_pkg::EV_COMPLETE; nev = 3'd2;
                                end
                                n_state = aps_pkg::ST_G3;
                            end else if (r_state == aps_pkg::ST_S4S3) begin
                                ev[0] = aps_pkg::EV_STARTUP; nev = 3'd1;
                                n_state = aps_pkg::ST_S3;
                            end else if (r_state == aps_pkg::ST_S3) begin
                                if (wv[0] && !sig[1]) n_state = aps_pkg::ST_S3S0;
                                else if (wv[1] && sig[2]) n_state = aps_pkg::ST_S3S4;
                            end else if (r_state == aps_pkg::ST_S3S0) begin
                                if (!rsm) n_state = aps_pkg::ST_S3;
                                else if (sig[5]) begin
                                    n_ds = 1'b0;
                                    ev[0] = aps_pkg::EV_RESUME; nev = 3'd1;
                                    n_state = aps_pkg::ST_S0;
                                end
                            end else begin
                                if (wv[0] && sig[1]) n_state = aps_pkg::ST_S0S3;
                                else if (i_cfg.s0ix_enable) begin
                                    if (i_item.host_sleep == aps_pkg::HS_SUSPEND && sig[0])
                                        n_state = aps_pkg::ST_S0S0IX;
                                    else if (i_item.host_sleep == aps_pkg::HS_RESUME) begin
                                        ev[0] = aps_pkg::EV_SLEEP_RESUME; nev = 3'd1;
                                    end
                                end
                            end
                        end
                        aps_pkg::ST_S0IX: begin
                            if (i_cfg.s0ix_enable) begin
                                if (!sig[0] && wv[0] && !sig[1]) n_state = aps_pkg::ST_S0IXS0;
                                else if (!sig[7]) n_state = aps_pkg::ST_S0;
                            end
                        end
                        aps_pkg::ST_S0S0IX: begin
                            if (i_cfg.s0ix_enable) begin
                                if (i_item.host_sleep == aps_pkg::HS_SUSPEND) begin
                                    ev[0] = aps_pkg::EV_SLEEP_SUSPEND;
                                    ev[1] = aps_pkg::EV_S0IX_SUSPEND; nev = 3'd2;
                                end else begin
                                    ev[0] = aps_pkg::EV_S0IX_SUSPEND; nev = 3'd1;
                                end
                                n_ds = 1'b1;
                                n_state = aps_pkg::ST_S0IX;
                            end
                        end
                        aps_pkg::ST_S0IXS0: begin
                            if (i_cfg.s0ix_enable) begin
                                n_ds = 1'b0;
                                ev[0] = aps_pkg::EV_S0IX_RESUME; nev = 3'd1;
                                n_state = aps_pkg::ST_S0;
                            end
                        end
                        aps_pkg::ST_S4S5: begin
                            ev[0] = aps_pkg::EV_SHUTDOWN;
                            ev[1] = aps_pkg::EV_COMPLETE; nev = 3'd2;
                            n_state = aps_pkg::ST_S5;
                        end
                        aps_pkg::ST_S3S4: n_state = aps_pkg::ST_S4;
                        aps_pkg::ST_S0S3: begin
                            ev[0] = aps_pkg::EV_SUSPEND; nev = 3'd1;
                            n_ds = 1'b1;
                            n_state = aps_pkg::ST_S3;
                        end
                        default: ;
                    endcase
                end
                aps_pkg::OP_TICK: begin
                    if (r_run && r_s5cnt != '0) n_s5cnt = r_s5cnt - 1'b1;
                    if (r_dcnt != '0) n_dcnt = r_dcnt - 1'b1;
                end
                aps_pkg::OP_START: begin
                    n_pending = 1'b1;
                    if (r_state == aps_pkg::ST_S5) n_run = 1'b0;
                end
                default: ;
            endcase
            if (nev == 3'd0) nev = 3'd1;
        end
        // rearm takes effect outside items; the user must write config only while idle, the block does not enforce it
        if (i_delay_rearm) n_armed = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aps_pkg::ST_G3; r_pending <= 1'b0; r_run <= 1'b0;
            r_s5cnt <= '0; r_dcnt <= '0; r_armed <= 1'b1;
            r_rsm <= 1'b1; r_ds <= 1'b1; o_step_valid <= 1'b0;
        end else begin
            r_state <= n_state; r_pending <= n_pending; r_run <= n_run;
            r_s5cnt <= n_s5cnt; r_dcnt <= n_dcnt; r_armed <= n_armed;
            r_rsm <= n_rsm; r_ds <= n_ds; o_step_valid <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        o_step.seq_state     <= n_state;
        o_step.rsmrst_assert <= n_rsm;
        o_step.deep_sleep_ok <= n_ds;
        o_step.nev           <= nev;
        o_step.ev            <= ev;
    end
endmodule

// ===== sv/aps_back.sv =====
// Back end: step queue and event serializer toward the result port
`timescale 1ns / 1ps
module aps_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step_valid,
    input  aps_pkg::t_step   i_step,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_qfull,
    output aps_pkg::t_out_item o_item
);
    aps_pkg::t_step r_q [aps_pkg::QDepth];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic [1:0] r_ev;
    logic       take, last;
    aps_pkg::t_step head;

    assign head    = r_q[r_rp];
    assign o_empty = r_cnt == 3'd0;
    // count the step already in flight from the front end
    assign o_qfull = r_cnt + 3'(i_step_valid) >= 3'(aps_pkg::QDepth);
    assign take    = i_pop && !o_empty;
    assign last    = 3'({1'b0, r_ev}) + 3'd1 == head.nev;

    assign o_item.seq_state     = head.seq_state;
    assign o_item.event_res     = head.ev[r_ev];
    assign o_item.rsmrst_assert = head.rsmrst_assert;
    assign o_item.deep_sleep_ok = head.deep_sleep_ok;
    assign o_item.last          = last;

    always_ff @(posedge i_clk) begin
        if (i_step_valid) r_q[r_wp] <= i_step;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0; r_ev <= '0;
        end else begin
            if (i_step_valid) r_wp <= r_wp + 1'b1;
            if (take) begin
                if (last) begin
                    r_rp <= r_rp + 1'b1;
                    r_ev <= '0;
                end else begin
                    r_ev <= r_ev + 1'b1;
                end
            end
            r_cnt <= r_cnt + 3'(i_step_valid) - 3'(take && last);
        end
    end
endmodule

// ===== sv/acpi_power_state_sequencer_top.sv =====
// Top level of the ACPI sleep-state power sequencer
//  channel   dir  handshake             payload
//  input     in   i_push / o_full       i_item (t_in_item)
//  result    out  o_empty / i_pop       o_item (t_out_item)
//  config    in   APB psel/penable      paddr, pwdata, prdata
// An item is classified in the cycle it is accepted; its step is queued the next cycle.
// One input item is taken per cycle while the four-entry step queue has room.
// Each item yields one to three result items, one per cycle while i_pop is high, so
// the rate is set by the result port: items with one event flow at one per cycle.
// Reset is synchronous; the block enters G3 with RSMRST asserted.
`timescale 1ns / 1ps
`include "acpi_power_state_sequencer_top_macros.svh"
module acpi_power_state_sequencer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  aps_pkg::t_in_item  i_item,
    output logic               o_empty,
    input  logic               i_pop,
    output aps_pkg::t_out_item o_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    aps_pkg::t_cfg  cfg;
    logic           rearm, step_valid, qfull, acc;
    aps_pkg::t_step step;

    assign o_full = qfull;
    assign acc = i_push && !o_full;

    aps_cfg u_cfg (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
        .prdata, .pready, .o_cfg(cfg), .o_delay_rearm(rearm)
    );

    aps_front u_front (
        .i_clk, .i_rst_n, .i_cfg(cfg), .i_delay_rearm(rearm), .i_push(acc),
        .i_item, .o_step_valid(step_valid), .o_step(step)
    );

    aps_back u_back (
        .i_clk, .i_rst_n, .i_step_valid(step_valid), .i_step(step), .i_pop,
        .o_empty, .o_qfull(qfull), .o_item
    );

    `APS_ASSERT_NEXT(a_step_follows, i_clk, i_rst_n, acc, step_valid, "accepted item lost")
    `APS_ASSERT_IMPL(a_step_nev, i_clk, i_rst_n, step_valid,
        step.nev != 3'd0 && step.nev <= 3'd4, "bad event count")
    `APS_ASSERT_IMPL(a_none_last, i_clk, i_rst_n, !o_empty && o_item.event_res == aps_pkg::EV_NONE,
        o_item.last, "empty event not last")
endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the ACPI power sequencer: state-walking stimulus with a local predictor
`timescale 1ns / 1ps
module tb;
    localparam int CycleLimit = 400000;
    localparam int PhaseItems = 50;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_push = 1'b0;
    logic o_full;
    aps_pkg::t_in_item i_item = '0;
    logic o_empty;
    logic i_pop = 1'b0;
    aps_pkg::t_out_item o_item;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    acpi_power_state_sequencer_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(i_push), .o_full(o_full),
        .i_item(i_item), .o_empty(o_empty), .i_pop(i_pop), .o_item(o_item),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    aps_pkg::t_in_item pending_items[$];
    aps_pkg::t_out_item expected_results[$];
    int fail_count = 0;
    int cycle_count = 0;

    // predictor copy of the registers and state
    logic [16:0] m_s5_timeout = 17'd10;
    logic [15:0] m_start_delay = '0;
    logic [7:0] m_mask = 8'd16;
    logic [7:0] m_value = 8'd16;
    logic m_debug_hold = 1'b0;
    logic m_s0ix_en = 1'b0;
    logic [3:0] m_state = aps_pkg::ST_G3;
    logic m_start_pend = 1'b0;
    logic m_timer_run = 1'b0;
    logic [15:0] m_timer_cnt = '0;
    logic [15:0] m_delay_cnt = '0;
    logic m_delay_armed = 1'b1;
    logic m_rsmrst = 1'b1;
    logic m_deep_sleep = 1'b1;
    logic [3:0] step_events[$];

    task automatic report_mismatch(input string what);
        $display("[%0d] mismatch: %s", cycle_count, what);
        fail_count++;
    endtask

    function automatic void note_event(input logic [3:0] e);
        if (step_events.size() < 4) step_events.push_back(e);
    endfunction

    function automatic void note_forced(input logic [3:0] e);
        if (!m_debug_hold) note_event(e);
    endfunction

    function automatic void note_power_loss();
        note_event(aps_pkg::EV_SHUTDOWN);
        note_forced(aps_pkg::EV_FORCE_FAIL);
        note_event(aps_pkg::EV_COMPLETE);
    endfunction

    function automatic logic [3:0] next_seq_state(input aps_pkg::t_in_item it);
        logic rsm, prim;
        logic [7:0] s;
        logic [2:0] wv;
        s = it.signals;
        wv = it.wire_valid;
        rsm = s[4];
        prim = s[6];
        case (m_state)
            aps_pkg::ST_G3: begin
                if (!m_start_pend) return m_state;
                if (m_delay_armed) begin
                    m_delay_cnt = m_start_delay;
                    m_delay_armed = 1'b0;
                end
                if (m_delay_cnt != 0) return m_state;
                m_start_pend = 1'b0;
                return it.startup_ok ? aps_pkg::ST_G3S5 : aps_pkg::ST_G3;
            end
            aps_pkg::ST_G3S5:
                return ((s & m_mask) == m_value) ? aps_pkg::ST_S5 : aps_pkg::ST_S5G3;
            aps_pkg::ST_S5: begin
                if (it.rails_enabled && rsm) begin
                    m_rsmrst = 1'b0;
                    if (wv[2] && !s[3]) begin
                        m_timer_run = 1'b0;
                        m_start_pend = 1'b0;
                        return aps_pkg::ST_S5S4;
                    end
                end
                if (m_s5_timeout == 0) begin
                    m_timer_run = 1'b0;
                    return aps_pkg::ST_S5G3;
                end
                // negative timeout: the S5 timer never expires
                if (!m_s5_timeout[16]) begin
                    if (!m_timer_run) begin
                        m_timer_run = 1'b1;
                        m_timer_cnt = m_s5_timeout[15:0];
                    end else if (m_timer_cnt == 0) begin
                        m_timer_run = 1'b0;
                        return aps_pkg::ST_S5G3;
                    end
                end
                return m_state;
            end
            aps_pkg::ST_S5G3: begin
                note_forced(aps_pkg::EV_FORCE_G3);
                note_event(aps_pkg::EV_HARDOFF);
                return aps_pkg::ST_G3;
            end
            aps_pkg::ST_S5S4: return rsm ? aps_pkg::ST_S4 : aps_pkg::ST_S5;
            aps_pkg::ST_S4: begin
                if ((wv[2] && s[3]) || !rsm) return aps_pkg::ST_S4S5;
                if (wv[1] && !s[2]) return aps_pkg::ST_S4S3;
                return m_state;
            end
            aps_pkg::ST_S4S3: begin
                if (!prim) begin
                    note_power_loss();
                    return aps_pkg::ST_G3;
                end
                note_event(aps_pkg::EV_STARTUP);
                return aps_pkg::ST_S3;
            end
            aps_pkg::ST_S3: begin
                if (!rsm) return aps_pkg::ST_S3S4;
                if (!prim) begin
                    note_power_loss();
                    return aps_pkg::ST_G3;
                end
                if (wv[0] && !s[1]) return aps_pkg::ST_S3S0;
                if (wv[1] && s[2]) return aps_pkg::ST_S3S4;
                return m_state;
            end
            aps_pkg::ST_S3S0: begin
                if (!prim) begin
                    note_power_loss();
                    return aps_pkg::ST_G3;
                end
                if (!rsm) return aps_pkg::ST_S3;
                if (s[5]) begin
                    m_deep_sleep = 1'b0;
                    note_event(aps_pkg::EV_RESUME);
                    return aps_pkg::ST_S0;
                end
                return m_state;
            end
            aps_pkg::ST_S0IX: begin
                if (!m_s0ix_en) return m_state;
                if (!s[0] && wv[0] && !s[1]) return aps_pkg::ST_S0IXS0;
                if (!s[7]) return aps_pkg::ST_S0;
                return m_state;
            end
            aps_pkg::ST_S0S0IX: begin
                if (!m_s0ix_en) return m_state;
                if (it.host_sleep == aps_pkg::HS_SUSPEND)
                    note_event(aps_pkg::EV_SLEEP_SUSPEND);
                note_event(aps_pkg::EV_S0IX_SUSPEND);
                m_deep_sleep = 1'b1;
                return aps_pkg::ST_S0IX;
            end
            aps_pkg::ST_S0IXS0: begin
                if (!m_s0ix_en) return m_state;
                m_deep_sleep = 1'b0;
                note_event(aps_pkg::EV_S0IX_RESUME);
                return aps_pkg::ST_S0;
            end
            aps_pkg::ST_S0: begin
                if (!prim) begin
                    note_power_loss();
                    return aps_pkg::ST_G3;
                end
                if (wv[0] && s[1]) return aps_pkg::ST_S0S3;
                if (m_s0ix_en) begin
                    if (it.host_sleep == aps_pkg::HS_SUSPEND && s[0])
                        return aps_pkg::ST_S0S0IX;
                    if (it.host_sleep == aps_pkg::HS_RESUME)
                        note_event(aps_pkg::EV_SLEEP_RESUME);
                end
                return m_state;
            end
            aps_pkg::ST_S4S5: begin
                note_event(aps_pkg::EV_SHUTDOWN);
                note_event(aps_pkg::EV_COMPLETE);
                return aps_pkg::ST_S5;
            end
            aps_pkg::ST_S3S4: return aps_pkg::ST_S4;
            aps_pkg::ST_S0S3: begin
                note_event(aps_pkg::EV_SUSPEND);
                m_deep_sleep = 1'b1;
                return aps_pkg::ST_S3;
            end
            default: return m_state;
        endcase
    endfunction

    // queue the item and the results it must produce
    function automatic void queue_item(input aps_pkg::t_in_item it);
        aps_pkg::t_out_item r;
        pending_items.push_back(it);
        step_events.delete();
        case (it.op)
            aps_pkg::OP_EVAL: m_state = next_seq_state(it);
            aps_pkg::OP_TICK: begin
                if (m_timer_run && m_timer_cnt != 0) m_timer_cnt--;
                if (m_delay_cnt != 0) m_delay_cnt--;
            end
            aps_pkg::OP_START: begin
                m_start_pend = 1'b1;
                if (m_state == aps_pkg::ST_S5) m_timer_run = 1'b0;
            end
            default: ;
        endcase
        if (step_events.size() == 0) step_events.push_back(aps_pkg::EV_NONE);
        foreach (step_events[k]) begin
            r.seq_state = m_state;
            r.event_res = step_events[k];
            r.rsmrst_assert = m_rsmrst;
            r.deep_sleep_ok = m_deep_sleep;
            r.last = (k == step_events.size() - 1);
            expected_results.push_back(r);
        end
    endfunction

    function automatic aps_pkg::t_in_item make_item(input logic [1:0] op,
                                                    input logic [7:0] s,
                                                    input logic [2:0] wv,
                                                    input logic [1:0] hs);
        aps_pkg::t_in_item it;
        it.op = op;
        it.signals = s;
        it.wire_valid = wv;
        it.rails_enabled = 1'b1;
        it.startup_ok = 1'b1;
        it.host_sleep = hs;
        return it;
    endfunction

    function automatic aps_pkg::t_in_item noise_item();
        aps_pkg::t_in_item it;
        it = aps_pkg::t_in_item'($urandom);
        return it;
    endfunction

    // pick an item that tends to move the sequencer forward from its present state
    function automatic aps_pkg::t_in_item guided_item();
        aps_pkg::t_in_item it;
        logic [3:0] slp;
        slp = 4'b0000;
        it = make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0);
        case (m_state)
            aps_pkg::ST_G3: begin
                if (!m_start_pend) it.op = aps_pkg::OP_START;
                else if (m_delay_cnt != 0 && !m_delay_armed) it.op = aps_pkg::OP_TICK;
                it.startup_ok = ($urandom_range(0, 7) != 0);
            end
            aps_pkg::ST_G3S5: begin
                if ($urandom_range(0, 5) != 0)
                    it.signals = (8'($urandom) & ~m_mask) | (m_value & m_mask);
                else it.signals = 8'($urandom);
            end
            aps_pkg::ST_S5: begin
                if ($urandom_range(0, 3) == 0) begin
                    it.rails_enabled = 1'b0;
                    if ($urandom_range(0, 1) == 0) it.op = aps_pkg::OP_TICK;
                end
                if ($urandom_range(0, 7) == 0) it.op = aps_pkg::OP_START;
            end
            aps_pkg::ST_S4: if ($urandom_range(0, 5) == 0) slp = 4'b1000;
            aps_pkg::ST_S3: if ($urandom_range(0, 4) == 0) slp = 4'b0110;
            aps_pkg::ST_S0: begin
                if (m_s0ix_en && $urandom_range(0, 2) == 0) begin
                    slp = 4'b0001;
                    it.host_sleep = aps_pkg::HS_SUSPEND;
                end else if ($urandom_range(0, 3) == 0) begin
                    slp = 4'b0010;
                end else if ($urandom_range(0, 7) == 0) begin
                    it.signals[6] = 1'b0;
                end else begin
                    it.host_sleep = 2'($urandom_range(0, 3));
                end
            end
            aps_pkg::ST_S0IX: if ($urandom_range(0, 3) == 0) it.signals[7] = 1'b0;
            default: it.host_sleep = 2'($urandom_range(0, 3));
        endcase
        if (m_state != aps_pkg::ST_G3S5) it.signals[3:0] = slp;
        if ($urandom_range(0, 9) == 0) it.signals ^= 8'(1 << $urandom_range(0, 7));
        if ($urandom_range(0, 9) == 0) it.wire_valid = 3'($urandom);
        if ($urandom_range(0, 11) == 0) it.op = aps_pkg::OP_TICK;
        return it;
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            aps_pkg::REG_S5_TIMEOUT: m_s5_timeout = v[16:0];
            aps_pkg::REG_START_DELAY: begin
                m_start_delay = v[15:0];
                m_delay_armed = 1'b1;
            end
            aps_pkg::REG_G3S5_MASK: m_mask = v[7:0];
            aps_pkg::REG_G3S5_VALUE: m_value = v[7:0];
            aps_pkg::REG_DEBUG_HOLD: m_debug_hold = v[0];
            aps_pkg::REG_S0IX_ENABLE: m_s0ix_en = v[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic run_random(input int n);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) queue_item(noise_item());
            else queue_item(guided_item());
        end
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        logic nxt_push;
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) void'(pending_items.pop_front());
            nxt_push = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_items.size() != 0) begin
                nxt_push = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 12);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end
            i_push <= nxt_push;
            if (nxt_push) i_item <= pending_items[0];
        end
    end

    // receiver: the stall density is picked anew at random moments
    int stall_mode = 0;
    always @(posedge i_clk) begin
        aps_pkg::t_out_item want;
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", o_item));
                end else begin
                    want = expected_results.pop_front();
                    if (o_item.seq_state !== want.seq_state)
                        report_mismatch($sformatf("seq_state %0d, want %0d",
                                                  o_item.seq_state, want.seq_state));
                    if (o_item.event_res !== want.event_res)
                        report_mismatch($sformatf("event_res %0d, want %0d",
                                                  o_item.event_res, want.event_res));
                    if (o_item.rsmrst_assert !== want.rsmrst_assert)
                        report_mismatch($sformatf("rsmrst_assert %b, want %b",
                                                  o_item.rsmrst_assert, want.rsmrst_assert));
                    if (o_item.deep_sleep_ok !== want.deep_sleep_ok)
                        report_mismatch($sformatf("deep_sleep_ok %b, want %b",
                                                  o_item.deep_sleep_ok, want.deep_sleep_ok));
                    if (o_item.last !== want.last)
                        report_mismatch($sformatf("last %b, want %b", o_item.last, want.last));
                end
            end
            if ($urandom_range(0, 39) == 0) stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: i_pop <= 1'b1;
                1: i_pop <= ($urandom_range(0, 3) != 0);
                2: i_pop <= ($urandom_range(0, 1) != 0);
                default: i_pop <= ($urandom_range(0, 5) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed walk with defaults: G3 up to S0, back down, power loss, odd codes
        queue_item(make_item(aps_pkg::OP_NONE, 8'hFF, 3'b111, 2'd3));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'h00, 3'b000, 2'd0));
        queue_item(make_item(aps_pkg::OP_START, 8'h00, 3'b000, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF8, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF4, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hD0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF2, 3'b111, 2'd3));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hF2, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'hB0, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_TICK, 8'hFF, 3'b111, 2'd0));
        queue_item(make_item(aps_pkg::OP_EVAL, 8'h00, 3'b111, 2'd0));
        wait_drained();
        run_random(PhaseItems);
        wait_drained();

        // zero timeout, start delay, strict G3S5 check, forced events held off, S0ix on
        write_register(aps_pkg::REG_S5_TIMEOUT, 32'd0);
        write_register(aps_pkg::REG_START_DELAY, 32'd3);
        write_register(aps_pkg::REG_G3S5_MASK, 32'hFF);
        write_register(aps_pkg::REG_G3S5_VALUE, 32'hF0);
        write_register(aps_pkg::REG_DEBUG_HOLD, 32'd1);
        write_register(aps_pkg::REG_S0IX_ENABLE, 32'd1);
        run_random(PhaseItems);
        wait_drained();

        // timeout never, no mask
        write_register(aps_pkg::REG_S5_TIMEOUT, 32'h1FFFF);
        write_register(aps_pkg::REG_START_DELAY, 32'd0);
        write_register(aps_pkg::REG_G3S5_MASK, 32'h00);
        write_register(aps_pkg::REG_G3S5_VALUE, 32'h00);
        write_register(aps_pkg::REG_DEBUG_HOLD, 32'd0);
        run_random(PhaseItems);
        wait_drained();

        // S0ix cleared while possibly in an S0ix state; short timer
        write_register(aps_pkg::REG_S0IX_ENABLE, 32'd0);
        write_register(aps_pkg::REG_S5_TIMEOUT, 32'd2);
        write_register(aps_pkg::REG_G3S5_MASK, 32'h10);
        write_register(aps_pkg::REG_G3S5_VALUE, 32'($urandom_range(0, 255)));
        run_random(PhaseItems);
        wait_drained();

        // largest values
        write_register(aps_pkg::REG_S5_TIMEOUT, 32'd65535);
        write_register(aps_pkg::REG_START_DELAY, 32'd65535);
        write_register(aps_pkg::REG_G3S5_MASK, 32'hFF);
        write_register(aps_pkg::REG_G3S5_VALUE, 32'hFF);
        write_register(aps_pkg::REG_S0IX_ENABLE, 32'd1);
        run_random(PhaseItems);
        wait_drained();

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== acpi_power_state_sequencer_top.f =====
+incdir+sv
sv/aps_pkg.sv
sv/aps_cfg.sv
sv/aps_front.sv
sv/aps_back.sv
sv/acpi_power_state_sequencer_top.sv
bench/tb.sv
